[rtl/upr_pkg.sv]
package upr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_FACTOR = 100;

  localparam int PIX_W   = 24;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W   = 11;
  localparam int FAC_W   = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register select is paddr[2]
  localparam logic REG_SCALE_FACTOR = 1'b0;
  localparam logic REG_IN_WIDTH     = 1'b1;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [1:0] STATUS_STORED  = 2'd0;
  localparam logic [1:0] STATUS_GIVEN   = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  function automatic logic [FAC_W-1:0] eff_factor(input logic [FAC_W-1:0] f);
    logic [FAC_W-1:0] r;
    r = f;
    if (f == '0) begin
      r = FAC_W'(1);
    end else if (f > FAC_W'(MAX_FACTOR)) begin
      r = FAC_W'(MAX_FACTOR);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_width(input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (w > CNT_W'(MAX_WIDTH)) begin
      r = CNT_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  // zero bytes that bring 3*w*f bytes up to a multiple of four
  function automatic logic [1:0] pad_calc(input logic [1:0] w2, input logic [1:0] f2);
    logic [1:0] bytes_mod;
    bytes_mod = 2'(2'(w2 * f2) * 2'd3);
    return 2'(2'd0 - bytes_mod);
  endfunction

endpackage

[rtl/upr_ram.sv]
module upr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/pixel_replicate_upscaler.sv]
// Integer nearest-neighbor upscaler. Load beats (action 0) fill a line RAM with
// one source row of in_width pixels; request beats (action 1) then return the
// enlarged output one pixel at a time, each source pixel repeated scale_factor
// times across a row and each row scale_factor times. Every input beat gives
// exactly one result beat. A load or a refused beat presents its result the
// cycle after acceptance; a granted request first passes through the READ
// state, the registered read of the single-port line RAM, before it presents
// its result. One beat is in flight at a time, and the next input is taken
// the cycle after the result leaves; while out_stall is high the result is
// held. Configure only while idle.
module pixel_replicate_upscaler (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [upr_pkg::ADDR_W-1:0]   paddr,
  input  logic [upr_pkg::DATA_W-1:0]   pwdata,
  output logic [upr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         row_end,
  output logic [1:0]                   pad_bytes,
  output logic                         block_end
);

  upr_pkg::state_t state;

  logic [upr_pkg::FAC_W-1:0] scale_factor;
  logic [upr_pkg::CNT_W-1:0] in_width;

  logic [upr_pkg::CNT_W-1:0] load_count;
  logic                      row_ready;
  logic [upr_pkg::COL_W-1:0] source_column;
  logic [upr_pkg::FAC_W-1:0] horizontal_repeat;
  logic [upr_pkg::FAC_W-1:0] vertical_repeat;

  logic [upr_pkg::FAC_W-1:0] f;
  logic [upr_pkg::CNT_W-1:0] w;
  logic                      accept;
  logic                      load_ok;
  logic                      give;
  logic                      l_wrap;
  logic                      h_wrap;
  logic                      c_wrap;
  logic                      v_wrap;
  logic                      cfg_wr;

  logic                      ram_we;
  logic [upr_pkg::COL_W-1:0] ram_addr;
  logic [upr_pkg::PIX_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      upr_pkg::REG_SCALE_FACTOR: prdata = upr_pkg::DATA_W'(scale_factor);
      upr_pkg::REG_IN_WIDTH:     prdata = upr_pkg::DATA_W'(in_width);
      default:                   prdata = '0;
    endcase
  end

  assign f = upr_pkg::eff_factor(scale_factor);
  assign w = upr_pkg::eff_width(in_width);

  assign in_stall  = (state != upr_pkg::S_IDLE);
  assign out_valid = (state == upr_pkg::S_SEND);
  assign accept    = in_valid && !in_stall;
  assign load_ok   = (action == upr_pkg::ACT_LOAD) && !row_ready;
  assign give      = (action == upr_pkg::ACT_REQUEST) && row_ready;

  assign l_wrap = ({1'b0, load_count} + (upr_pkg::CNT_W+1)'(1)) >= {1'b0, w};
  assign h_wrap = ({1'b0, horizontal_repeat} + (upr_pkg::FAC_W+1)'(1)) >= {1'b0, f};
  assign c_wrap = ({1'b0, source_column} + (upr_pkg::COL_W+1)'(1)) >= w;
  assign v_wrap = ({1'b0, vertical_repeat} + (upr_pkg::FAC_W+1)'(1)) >= {1'b0, f};

  assign ram_we   = accept && load_ok && (load_count < upr_pkg::CNT_W'(upr_pkg::MAX_WIDTH));
  assign ram_addr = ram_we ? load_count[upr_pkg::COL_W-1:0] : source_column;

  upr_ram #(
    .WIDTH (upr_pkg::PIX_W),
    .DEPTH (upr_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({red, green, blue}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= upr_pkg::FAC_W'(1);
      in_width     <= upr_pkg::CNT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        upr_pkg::REG_SCALE_FACTOR: scale_factor <= pwdata[upr_pkg::FAC_W-1:0];
        upr_pkg::REG_IN_WIDTH:     in_width     <= pwdata[upr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= upr_pkg::S_IDLE;
      load_count        <= '0;
      row_ready         <= 1'b0;
      source_column     <= '0;
      horizontal_repeat <= '0;
      vertical_repeat   <= '0;
    end else begin
      unique case (state)
        upr_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= upr_pkg::S_SEND;
            if (load_ok) begin
              if (l_wrap) begin
                load_count <= '0;
                row_ready  <= 1'b1;
              end else begin
                load_count <= load_count + upr_pkg::CNT_W'(1);
              end
            end else if (give) begin
              state <= upr_pkg::S_READ;
              if (!h_wrap) begin
                horizontal_repeat <= horizontal_repeat + upr_pkg::FAC_W'(1);
              end else begin
                horizontal_repeat <= '0;
                if (!c_wrap) begin
                  source_column <= source_column + upr_pkg::COL_W'(1);
                end else begin
                  source_column <= '0;
                  if (v_wrap) begin
                    vertical_repeat <= '0;
                    row_ready       <= 1'b0;
                  end else begin
                    vertical_repeat <= vertical_repeat + upr_pkg::FAC_W'(1);
                  end
                end
              end
            end
          end
        end
        upr_pkg::S_READ: begin
          state <= upr_pkg::S_SEND;
        end
        upr_pkg::S_SEND: begin
          if (!out_stall) begin
            state <= upr_pkg::S_IDLE;
          end
        end
        default: begin
          state <= upr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // result beat: flags settle at acceptance, pixel lands after the ram read
  always_ff @(posedge clk) begin
    if (accept) begin
      out_red   <= '0;
      out_green <= '0;
      out_blue  <= '0;
      row_end   <= give && h_wrap && c_wrap;
      pad_bytes <= (give && h_wrap && c_wrap) ? upr_pkg::pad_calc(w[1:0], f[1:0]) : 2'd0;
      block_end <= give && h_wrap && c_wrap && v_wrap;
      priority if (load_ok) begin
        status <= upr_pkg::STATUS_STORED;
      end else if (give) begin
        status <= upr_pkg::STATUS_GIVEN;
      end else begin
        status <= upr_pkg::STATUS_REFUSED;
      end
    end else if (state == upr_pkg::S_READ) begin
      {out_red, out_green, out_blue} <= ram_rdata;
    end
  end

endmodule

[rtl/upr_checker.sv]
module upr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic [7:0]                 out_red,
  input logic [7:0]                 out_green,
  input logic [7:0]                 out_blue,
  input logic                       row_end,
  input logic [1:0]                 pad_bytes,
  input logic                       block_end
);

  // a held result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(row_end)
      && $stable(pad_bytes) && $stable(block_end))
    else $error("result beat changed while stalled");

  // one beat in flight: no input taken while a result waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // every accepted beat is followed by a result before the next input
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice without a result");

  // only a given pixel carries color or row marks
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != upr_pkg::STATUS_GIVEN |->
      out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0
      && !row_end && pad_bytes == 2'd0 && !block_end)
    else $error("non-pixel result carries pixel fields");

  // block end only on a row end, and pad only on a row end
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (block_end || pad_bytes != 2'd0) |-> row_end)
    else $error("block end or pad without row end");

endmodule

bind pixel_replicate_upscaler upr_checker u_upr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .row_end   (row_end),
  .pad_bytes (pad_bytes),
  .block_end (block_end)
);

[sim/upscaler_beat_checker.sv]
`timescale 1ns / 1ps

module upscaler_beat_checker (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [upr_pkg::ADDR_W-1:0] paddr,
  input  logic [upr_pkg::DATA_W-1:0] pwdata,

  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       action,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,

  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 status,
  input  logic [7:0]                 out_red,
  input  logic [7:0]                 out_green,
  input  logic [7:0]                 out_blue,
  input  logic                       row_end,
  input  logic [1:0]                 pad_bytes,
  input  logic                       block_end,

  output int                         fail_count,
  output int                         pending,
  output logic                       row_busy
);

  import upr_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic [1:0] pad;
    logic       block_end;
  } px_beat_t;

  logic [FAC_W-1:0]  factor_reg;
  logic [CNT_W-1:0]  width_reg;

  logic [PIX_W-1:0]  line_px [MAX_WIDTH];
  logic [CNT_W-1:0]  load_cnt;
  logic              row_full;
  logic [COL_W-1:0]  src_col;
  logic [FAC_W-1:0]  h_rep;
  logic [FAC_W-1:0]  v_rep;

  px_beat_t          scaled_out_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    row_busy   = 1'b0;
  end

  task automatic scale_one_beat(input logic act, input logic [7:0] r, g, b);
    px_beat_t o;
    int       f;
    int       w;
    f = (factor_reg == 0) ? 1 : (factor_reg > MAX_FACTOR) ? MAX_FACTOR : int'(factor_reg);
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    o = '0;
    o.status = STATUS_REFUSED;
    if (act == ACT_LOAD) begin
      if (!row_full) begin
        if (load_cnt < MAX_WIDTH) line_px[load_cnt[COL_W-1:0]] = {r, g, b};
        load_cnt = load_cnt + 1'b1;
        if (load_cnt >= w) begin
          load_cnt = '0;
          row_full = 1'b1;
        end
        o.status = STATUS_STORED;
      end
    end else if (row_full) begin
      {o.red, o.green, o.blue} = line_px[src_col];
      o.status = STATUS_GIVEN;
      if (h_rep + 1 >= f) begin
        h_rep = '0;
        if (src_col + 1 >= w) begin
          src_col   = '0;
          o.row_end = 1'b1;
          o.pad     = 2'((4 - (3 * w * f) % 4) % 4);
          if (v_rep + 1 >= f) begin
            v_rep       = '0;
            row_full    = 1'b0;
            o.block_end = 1'b1;
          end else begin
            v_rep = v_rep + 1'b1;
          end
        end else begin
          src_col = src_col + 1'b1;
        end
      end else begin
        h_rep = h_rep + 1'b1;
      end
    end
    scaled_out_q.push_back(o);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    px_beat_t want;
    if (rst) begin
      factor_reg = FAC_W'(1);
      width_reg  = CNT_W'(1);
      load_cnt   = '0;
      row_full   = 1'b0;
      src_col    = '0;
      h_rep      = '0;
      v_rep      = '0;
      fail_count = 0;
      scaled_out_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SCALE_FACTOR) begin
          factor_reg = pwdata[FAC_W-1:0];
        end else if (paddr[2] == REG_IN_WIDTH) begin
          width_reg = pwdata[CNT_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        scale_one_beat(action, red, green, blue);
      end
      if (out_valid && !out_stall) begin
        if (scaled_out_q.size() == 0) begin
          $error("output beat with no input beat waiting for it");
          fail_count++;
        end else begin
          want = scaled_out_q.pop_front();
          check_field("status", want.status, status);
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("row_end", want.row_end, row_end);
          check_field("pad_bytes", want.pad, pad_bytes);
          check_field("block_end", want.block_end, block_end);
        end
      end
    end
    pending  = scaled_out_q.size();
    row_busy = row_full;
  end

endmodule

[sim/tb_pixel_replicate_upscaler.sv]
`timescale 1ns / 1ps

module tb_pixel_replicate_upscaler;

  import upr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORK_BEATS  = 1350;

  logic                clk = 1'b0;
  logic                rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                action = ACT_LOAD;
  logic [7:0]          red = '0;
  logic [7:0]          green = '0;
  logic [7:0]          blue = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic                row_end;
  logic [1:0]          pad_bytes;
  logic                block_end;

  int                  fail_count;
  int                  pending;
  logic                row_busy;

  int                  cycle_count = 0;
  int                  stall_left = 0;
  int                  work_done = 0;
  bit                  calm = 1'b0;

  pixel_replicate_upscaler DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .row_end(row_end), .pad_bytes(pad_bytes), .block_end(block_end)
  );

  upscaler_beat_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .row_end(row_end), .pad_bytes(pad_bytes), .block_end(block_end),
    .fail_count(fail_count), .pending(pending), .row_busy(row_busy)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_reg(input int val, input int hi);
    if (val < 1) return 1;
    if (val > hi) return hi;
    return val;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !calm && ($urandom_range(0, 2) == 0);
      stall_left <= gap_len();
    end
  end

  task automatic reg_write(input logic sel, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off until every beat sent has come back, then let the pipe settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_beat(input logic act, input logic [23:0] px);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action   <= act;
    red      <= px[23:16];
    green    <= px[15:8];
    blue     <= px[7:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_block();
    logic [FAC_W-1:0] f_reg;
    logic [CNT_W-1:0] w_reg;
    int f_eff;
    int w_eff;
    int r;
    int cut_at;
    int loaded;
    int given;
    int total;

    r = $urandom_range(0, 99);
    if (r < 60)      f_reg = $urandom_range(1, 4);
    else if (r < 85) f_reg = $urandom_range(5, 12);
    else if (r < 92) f_reg = 0;
    else if (r < 96) f_reg = $urandom_range(MAX_FACTOR, 127);
    else             f_reg = $urandom_range(13, MAX_FACTOR - 1);
    r = $urandom_range(0, 99);
    if (r < 60)      w_reg = $urandom_range(1, 8);
    else if (r < 85) w_reg = $urandom_range(9, 40);
    else if (r < 90) w_reg = 0;
    else if (r < 95) w_reg = $urandom_range(MAX_WIDTH, 2047);
    else             w_reg = $urandom_range(41, MAX_WIDTH - 1);
    f_eff = clamp_reg(f_reg, MAX_FACTOR);
    w_eff = clamp_reg(w_reg, MAX_WIDTH);

    wait_quiet();
    calm = ($urandom_range(0, 4) == 0);
    reg_write(REG_SCALE_FACTOR, DATA_W'(f_reg));
    reg_write(REG_IN_WIDTH, DATA_W'(w_reg));

    // wide rows get cut short mid-load, never wider than what has been written
    cut_at = (w_eff > 40) ? $urandom_range(1, 20) : -1;
    loaded = 0;
    while (!row_busy) begin
      if (loaded == cut_at) begin
        wait_quiet();
        w_reg = $urandom_range(0, loaded);
        w_eff = clamp_reg(w_reg, MAX_WIDTH);
        reg_write(REG_IN_WIDTH, DATA_W'(w_reg));
      end
      if ($urandom_range(0, 15) == 0) send_beat(ACT_REQUEST, 24'($urandom));
      send_beat(ACT_LOAD, 24'($urandom));
      loaded++;
      work_done++;
    end

    // long blocks always get a mid-row register change, some short ones too
    total  = w_eff * f_eff * f_eff;
    cut_at = (total > 300 || $urandom_range(0, 5) == 0) ?
             $urandom_range(1, (total > 300) ? 300 : total) : -1;
    given  = 0;
    while (row_busy) begin
      if (given == cut_at) begin
        wait_quiet();
        reg_write(REG_SCALE_FACTOR, DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) begin
          reg_write(REG_IN_WIDTH, DATA_W'($urandom_range(0, w_eff)));
        end
      end
      if ($urandom_range(0, 15) == 0) send_beat(ACT_LOAD, 24'($urandom));
      send_beat(ACT_REQUEST, 24'($urandom));
      given++;
      work_done++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // request with nothing loaded, then a one-pixel row with a busy load in between
    send_beat(ACT_REQUEST, 24'hFFFFFF);
    send_beat(ACT_LOAD, 24'hFFFFFF);
    send_beat(ACT_LOAD, 24'h000000);
    send_beat(ACT_REQUEST, 24'h000000);

    // zero in both registers acts as one
    wait_quiet();
    reg_write(REG_SCALE_FACTOR, '0);
    reg_write(REG_IN_WIDTH, '0);
    send_beat(ACT_LOAD, 24'h000000);
    send_beat(ACT_REQUEST, 24'hFFFFFF);

    // oversized and maximum settings, shrunk while loading and while giving out
    wait_quiet();
    reg_write(REG_SCALE_FACTOR, 32'd127);
    reg_write(REG_IN_WIDTH, DATA_W'(MAX_WIDTH));
    send_beat(ACT_LOAD, 24'hA55AC3);
    send_beat(ACT_LOAD, 24'h5AA53C);
    wait_quiet();
    reg_write(REG_IN_WIDTH, 32'd2047);
    send_beat(ACT_LOAD, 24'h0FF00F);
    wait_quiet();
    reg_write(REG_IN_WIDTH, 32'd2);
    send_beat(ACT_LOAD, 24'hF00FF0);
    repeat (5) send_beat(ACT_REQUEST, 24'h000000);
    wait_quiet();
    reg_write(REG_SCALE_FACTOR, DATA_W'(MAX_FACTOR));
    repeat (3) send_beat(ACT_REQUEST, 24'hFFFFFF);
    wait_quiet();
    reg_write(REG_SCALE_FACTOR, 32'd1);
    while (row_busy) send_beat(ACT_REQUEST, 24'h000000);

    while (work_done < WORK_BEATS) run_block();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/upr_pkg.sv
rtl/upr_ram.sv
rtl/pixel_replicate_upscaler.sv
rtl/upr_checker.sv
sim/upscaler_beat_checker.sv
sim/tb_pixel_replicate_upscaler.sv
